>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on clk, off while arst_n is low.
`define M3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define M3_ASSERT_IMP(lbl, ante, cons, msg) \
	`M3_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define M3_ASSERT_NXT(lbl, ante, cons, msg) \
	`M3_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> hw/rtl/m3ua_pkg.sv
// Types, constants and message-code decode for the M3UA message parser.
package m3ua_pkg;

	localparam int MAX_PARAMETERS    = 16;
	localparam int MAX_MESSAGE_BYTES = 65535;
	localparam int HDR_BYTES         = 8;
	localparam int PCNT_W            = $clog2(MAX_PARAMETERS + 1);

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [15:0] TAG_NA = 16'h0200;
	localparam logic [15:0] TAG_RC = 16'h0006;
	localparam logic [15:0] TAG_PD = 16'h0210;

	localparam logic [7:0] CLS_MGMT  = 8'd0;
	localparam logic [7:0] CLS_XFER  = 8'd1;
	localparam logic [7:0] CLS_SSNM  = 8'd2;
	localparam logic [7:0] CLS_ASPSM = 8'd3;
	localparam logic [7:0] CLS_ASPTM = 8'd4;
	localparam logic [7:0] CLS_RKM   = 8'd9;

	localparam logic [7:0] M3UA_VERSION = 8'd1;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_NA     = 3'd1,
		KIND_RC     = 3'd2,
		KIND_PD     = 3'd3,
		KIND_END    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEAD  = 2'd0,
		PH_VALUE = 2'd1,
		PH_PAD   = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  class_byte;
		logic [7:0]  type_byte;
		logic [4:0]  message_code;
		logic [31:0] param_value;
		logic [15:0] data_offset;
		logic [15:0] data_length;
		logic        detected;
		logic        last_result;
	} res_t;

	// Results produced by one accepted word: count, then up to two entries in order.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Dense code of a class/type pair, 0 when unknown.
	function automatic logic [4:0] code_of(input logic [7:0] c, input logic [7:0] t);
		logic [4:0] code;
		code = 5'd0;
		case (c)
			CLS_MGMT:  if (t <= 8'd1) code = 5'd1 + t[4:0];
			CLS_XFER:  if (t == 8'd1) code = 5'd3;
			CLS_SSNM:  if (t inside {[8'd1:8'd6]}) code = 5'd3 + t[4:0];
			CLS_ASPSM: if (t inside {[8'd1:8'd6]}) code = 5'd9 + t[4:0];
			CLS_ASPTM: if (t inside {[8'd1:8'd4]}) code = 5'd15 + t[4:0];
			CLS_RKM:   if (t inside {[8'd1:8'd4]}) code = 5'd19 + t[4:0];
			default:   code = 5'd0;
		endcase
		return code;
	endfunction

endpackage

>>> hw/rtl/m3ua_in_if.sv
// Input channel: one message byte per word.
interface m3ua_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       from_sctp_data;
	logic       last_byte;

	modport source(output valid, data_byte, from_sctp_data, last_byte, input ready);
	modport sink(input valid, data_byte, from_sctp_data, last_byte, output ready);
endinterface

>>> hw/rtl/m3ua_out_if.sv
// Output channel: one parse result per word.
interface m3ua_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  class_byte;
	logic [7:0]  type_byte;
	logic [4:0]  message_code;
	logic [31:0] param_value;
	logic [15:0] data_offset;
	logic [15:0] data_length;
	logic        detected;
	logic        last_result;

	modport source(output valid, kind, class_byte, type_byte, message_code, param_value,
		data_offset, data_length, detected, last_result, input ready);
	modport sink(input valid, kind, class_byte, type_byte, message_code, param_value,
		data_offset, data_length, detected, last_result, output ready);
endinterface

>>> hw/rtl/m3ua_core.sv
// Parser state: header capture, TLV walk, end verdict; emits up to two results per byte.
module m3ua_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            from_sctp_data,
	input  logic            last_byte,
	output m3ua_pkg::push_t push
);
	import m3ua_pkg::*;

	logic [15:0]       cnt_q, cnt_d;
	logic [63:0]       hdr_q, hdr_d;
	logic              sctp_q, sctp_d;
	phase_t            phase_q, phase_d;
	logic              stop_q, stop_d;
	logic [31:0]       ph_q, ph_d;
	logic [15:0]       left_q, left_d;
	logic [31:0]       vw_q, vw_d;
	logic [PCNT_W-1:0] pcnt_q, pcnt_d;

	// shared decode
	logic              in_range, in_hdr, hdr_en, walk_en;
	logic [63:0]       hdr_shift, hdr_new;
	logic [15:0]       cnt_new;
	logic              sctp_new;
	logic [31:0]       ph_shift, vw_shift;
	logic [15:0]       plen_h, vlen_v;
	logic              vw_take, head_done, short_len, fin;
	logic [31:0]       fin_hdr, fin_vw;
	logic [15:0]       fin_plen, fin_vlen, fin_tag;
	logic [1:0]        fin_pad;
	logic [PCNT_W-1:0] pcnt_inc;
	logic              det;

	assign in_range  = cnt_q < 16'(MAX_MESSAGE_BYTES);
	assign in_hdr    = cnt_q < 16'(HDR_BYTES);
	assign hdr_en    = accept && in_range && in_hdr;
	assign walk_en   = accept && in_range && !in_hdr && !stop_q;
	assign hdr_shift = {hdr_q[55:0], data_byte};
	assign hdr_new   = hdr_en ? hdr_shift : hdr_q;
	assign cnt_new   = (accept && in_range) ? cnt_q + 16'd1 : cnt_q;
	assign sctp_new  = (accept && in_range && cnt_q == 16'd0) ? from_sctp_data : sctp_q;

	assign ph_shift  = {ph_q[23:0], data_byte};
	assign vw_shift  = {vw_q[23:0], data_byte};
	assign plen_h    = ph_shift[15:0];
	assign vlen_v    = ph_q[15:0] - 16'd4;
	assign vw_take   = (vlen_v - left_q) < 16'd4;
	assign head_done = (phase_q == PH_HEAD) && (left_q == 16'd3);
	assign short_len = plen_h < 16'd4;

	// a parameter completes on this byte
	assign fin = walk_en && ((head_done && plen_h == 16'd4) ||
		(phase_q == PH_VALUE && left_q == 16'd1));
	assign fin_hdr  = (phase_q == PH_HEAD) ? ph_shift : ph_q;
	assign fin_vw   = (phase_q == PH_HEAD) ? 32'd0 : (vw_take ? vw_shift : vw_q);
	assign fin_plen = fin_hdr[15:0];
	assign fin_tag  = fin_hdr[31:16];
	assign fin_vlen = fin_plen - 16'd4;
	assign fin_pad  = 2'd0 - fin_plen[1:0];
	assign pcnt_inc = pcnt_q + PCNT_W'(1);

	assign det = sctp_new && (cnt_new >= 16'(HDR_BYTES)) &&
		(hdr_new[63:56] == M3UA_VERSION) &&
		(code_of(hdr_new[47:40], hdr_new[39:32]) != 5'd0) &&
		(hdr_new[31:0] == {16'd0, cnt_new});

	// next state
	always_comb begin
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		sctp_d  = sctp_q;
		phase_d = phase_q;
		stop_d  = stop_q;
		ph_d    = ph_q;
		left_d  = left_q;
		vw_d    = vw_q;
		pcnt_d  = pcnt_q;
		if (accept && in_range) begin
			cnt_d  = cnt_new;
			sctp_d = sctp_new;
		end
		if (hdr_en) begin
			hdr_d = hdr_shift;
		end
		if (walk_en) begin
			case (phase_q)
				PH_HEAD: begin
					ph_d   = ph_shift;
					left_d = left_q + 16'd1;
					if (head_done) begin
						if (short_len) begin
							stop_d = 1'b1;
						end else begin
							vw_d    = 32'd0;
							phase_d = PH_VALUE;
							left_d  = plen_h - 16'd4;
						end
					end
				end
				PH_VALUE: begin
					if (vw_take) vw_d = vw_shift;
					left_d = left_q - 16'd1;
				end
				PH_PAD: begin
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						phase_d = PH_HEAD;
						ph_d    = 32'd0;
					end
				end
				default: begin
					phase_d = PH_HEAD;
				end
			endcase
			if (fin) begin
				pcnt_d = pcnt_inc;
				if (fin_pad != 2'd0) begin
					phase_d = PH_PAD;
					left_d  = {14'd0, fin_pad};
				end else begin
					phase_d = PH_HEAD;
					left_d  = 16'd0;
					ph_d    = 32'd0;
				end
				if (pcnt_inc >= PCNT_W'(MAX_PARAMETERS)) stop_d = 1'b1;
			end
		end
		if (accept && last_byte) begin
			cnt_d   = 16'd0;
			hdr_d   = 64'd0;
			sctp_d  = 1'b0;
			phase_d = PH_HEAD;
			stop_d  = 1'b0;
			ph_d    = 32'd0;
			left_d  = 16'd0;
			vw_d    = 32'd0;
			pcnt_d  = '0;
		end
	end

	// results
	always_comb begin
		res_t w_res, e_res;
		logic w_valid, e_valid;
		w_res   = '0;
		e_res   = '0;
		w_valid = 1'b0;
		e_valid = accept && last_byte;
		if (hdr_en && cnt_q == 16'(HDR_BYTES - 1)) begin
			w_valid            = 1'b1;
			w_res.kind         = KIND_HEADER;
			w_res.class_byte   = hdr_shift[47:40];
			w_res.type_byte    = hdr_shift[39:32];
			w_res.message_code = code_of(hdr_shift[47:40], hdr_shift[39:32]);
		end else if (fin) begin
			if (fin_tag == TAG_NA && fin_vlen >= 16'd4) begin
				w_valid           = 1'b1;
				w_res.kind        = KIND_NA;
				w_res.param_value = fin_vw;
			end else if (fin_tag == TAG_RC && fin_vlen >= 16'd4) begin
				w_valid           = 1'b1;
				w_res.kind        = KIND_RC;
				w_res.param_value = fin_vw;
			end else if (fin_tag == TAG_PD) begin
				w_valid           = 1'b1;
				w_res.kind        = KIND_PD;
				w_res.data_offset = cnt_q + 16'd1 - fin_vlen;
				w_res.data_length = fin_vlen;
			end
		end
		w_res.last_result = !e_valid;
		e_res.kind        = KIND_END;
		e_res.detected    = det;
		e_res.last_result = 1'b1;
		push.n  = {1'b0, w_valid} + {1'b0, e_valid};
		push.r0 = w_valid ? w_res : e_res;
		push.r1 = e_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 16'd0;
			hdr_q   <= 64'd0;
			sctp_q  <= 1'b0;
			phase_q <= PH_HEAD;
			stop_q  <= 1'b0;
			ph_q    <= 32'd0;
			left_q  <= 16'd0;
			vw_q    <= 32'd0;
			pcnt_q  <= '0;
		end else begin
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
			sctp_q  <= sctp_d;
			phase_q <= phase_d;
			stop_q  <= stop_d;
			ph_q    <= ph_d;
			left_q  <= left_d;
			vw_q    <= vw_d;
			pcnt_q  <= pcnt_d;
		end
	end

endmodule

>>> hw/rtl/m3ua_rfifo.sv
// Small result queue: takes up to two results a cycle, hands out one while pop_ready is high.
module m3ua_rfifo (
	input  logic            clk,
	input  logic            arst_n,
	input  m3ua_pkg::push_t push,
	output logic            room,
	input  logic            pop_ready,
	output logic            head_valid,
	output m3ua_pkg::res_t  head
);
	import m3ua_pkg::*;

	res_t                 mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wp_q, rp_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign head_valid = cnt_q != '0;
	assign head       = mem[rp_q];
	assign pop        = head_valid && pop_ready;
	assign room       = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem[wp_q] <= push.r0;
		if (push.n == 2'd2) mem[RES_PTR_W'(wp_q + 1'b1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= RES_PTR_W'(wp_q + push.n);
			rp_q  <= RES_PTR_W'(rp_q + pop);
			cnt_q <= RES_CNT_W'(cnt_q + RES_CNT_W'(push.n) - RES_CNT_W'(pop));
		end
	end

endmodule

>>> hw/rtl/m3ua_message_parser.sv
// Top level of the M3UA message parser.
// Takes one M3UA message a byte per word, in wire order, at one byte per clock
// while the result queue has room, and gives results one per word: a header
// result after byte 8 (class, type, dense message code), one result per
// Network Appearance, Routing Context or Protocol Data parameter that fits
// wholly in the message (up to 16 parameters walked), and an end result with
// the detect verdict on the byte that carries last_byte. Parsing is a single
// registered pass: each accepted byte updates the parser registers and writes
// its results into a four-entry result queue in the same cycle. A byte yields
// zero, one or two results; the queue drains one per clock while the output is
// ready, and the input is held off only when the queue has fewer than two free
// entries (i.e. when the output is stalled or two-result bytes arrive faster
// than results are taken).
module m3ua_message_parser (
	input logic        clk,
	input logic        arst_n,
	m3ua_in_if.sink    msg_ch,
	m3ua_out_if.source res_ch
);
	import m3ua_pkg::*;

	logic  in_fire;
	logic  room;
	logic  head_valid;
	logic  out_ready;
	push_t push;
	res_t  head;

	// input side: byte accepted whenever the queue can take a worst-case two results
	assign msg_ch.ready = room;
	assign in_fire      = msg_ch.valid && room;
	assign out_ready    = res_ch.ready;

	m3ua_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_fire),
		.data_byte     (msg_ch.data_byte),
		.from_sctp_data(msg_ch.from_sctp_data),
		.last_byte     (msg_ch.last_byte),
		.push          (push)
	);

	// result queue doubles as the output register
	m3ua_rfifo u_rfifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.pop_ready (out_ready),
		.head_valid(head_valid),
		.head      (head)
	);

	assign res_ch.valid        = head_valid;
	assign res_ch.kind         = head.kind;
	assign res_ch.class_byte   = head.class_byte;
	assign res_ch.type_byte    = head.type_byte;
	assign res_ch.message_code = head.message_code;
	assign res_ch.param_value  = head.param_value;
	assign res_ch.data_offset  = head.data_offset;
	assign res_ch.data_length  = head.data_length;
	assign res_ch.detected     = head.detected;
	assign res_ch.last_result  = head.last_result;

endmodule

>>> hw/rtl/m3ua_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
`include "assert_macros.svh"

module m3ua_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input m3ua_pkg::res_t head
);
	import m3ua_pkg::*;

	logic is_end, is_hdr, code_ok;

	assign is_end  = out_valid && head.kind == KIND_END;
	assign is_hdr  = out_valid && head.kind == KIND_HEADER;
	assign code_ok = head.message_code == code_of(head.class_byte, head.type_byte);

	`M3_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(head), "word lost")
	`M3_ASSERT_IMP(a_end_last, is_end, head.last_result, "end result without last_result")
	`M3_ASSERT_IMP(a_det_end, out_valid && !is_end, !head.detected, "detected off end")
	`M3_ASSERT_IMP(a_hdr_code, is_hdr, code_ok, "header code does not match class and type")

endmodule

bind m3ua_message_parser m3ua_checker u_m3ua_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(head_valid),
	.out_ready(out_ready),
	.head     (head)
);
